// ----- hdl/ffa_pkg.sv -----
package ffa_pkg;

	localparam int MAX_ROWS          = 4;
	localparam int MAX_SLOTS_PER_ROW = 16;
	localparam int RUN_LENGTH        = 5;
	localparam int ID_W              = 16;

	localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int SLOT_W  = $clog2(MAX_SLOTS_PER_ROW);
	localparam int NSLOT_W = $clog2(MAX_SLOTS_PER_ROW + 1);
	localparam int NROW_W  = $clog2(MAX_ROWS + 1);
	localparam int RUN_W   = $clog2(RUN_LENGTH + 1);

	localparam int ROW_COUNT_W   = 3;
	localparam int SLOTS_W       = 5;
	localparam int CFG_W         = 5;
	localparam int OUT_ROW_W     = 2;
	localparam int OUT_SLOT_W    = 4;
	localparam int FREED_W       = 7;
	localparam int STATUS_W      = 2;
	localparam int IN_TDATA_W    = 24;
	localparam int OUT_TDATA_W   = 16;

	typedef enum logic [1:0] {
		OP_SINGLE = 2'd0,
		OP_RUN    = 2'd1,
		OP_FREE   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_PLACED    = 2'd0,
		STAT_NO_ROOM   = 2'd1,
		STAT_FREED     = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		REG_ROW_COUNT     = 1'b0,
		REG_SLOTS_PER_ROW = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

	typedef struct packed {
		logic               valid;
		logic               active;
		logic [ROW_W-1:0]   row;
		logic [RUN_W-1:0]   run;
		logic               found;
		logic [SLOT_W-1:0]  start;
		logic [NSLOT_W-1:0] cnt;
	} tok_t;

	typedef struct packed {
		logic              en;
		logic [ROW_W-1:0]  row;
		logic [SLOT_W-1:0] start;
		logic [RUN_W-1:0]  len;
	} commit_t;

	function automatic logic [RUN_W-1:0] run_len(input op_t op);
		return (op == OP_RUN) ? RUN_W'(RUN_LENGTH) : RUN_W'(1);
	endfunction

endpackage

// ----- hdl/ffa_cell.sv -----
module ffa_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ffa_pkg::SLOT_W-1:0] cell_idx,
	input  ffa_pkg::op_t               op,
	input  logic [ffa_pkg::ID_W-1:0]   id,
	input  logic [ffa_pkg::NSLOT_W-1:0] slots_use,
	input  ffa_pkg::commit_t           commit,
	input  ffa_pkg::tok_t              tok_in,
	output ffa_pkg::tok_t              tok_out
);
	import ffa_pkg::*;

	logic [MAX_ROWS-1:0] taken_q;
	logic [ID_W-1:0]     owner_q [MAX_ROWS];
	tok_t                tok_q;
	tok_t                nxt;
	logic                in_use;
	logic                cur_taken;
	logic                place;
	logic                clr;
	logic [RUN_W-1:0]    len;
	logic [RUN_W-1:0]    run;
	logic                hit;

	always_comb begin
		in_use    = {1'b0, cell_idx} < slots_use;
		cur_taken = taken_q[tok_in.row];
		place     = (op == OP_SINGLE) || (op == OP_RUN);
		len       = run_len(op);
		run       = RUN_W'(tok_in.run + 1'b1);
		nxt       = tok_in;
		clr       = 1'b0;
		if (tok_in.valid) begin
			if (place && tok_in.active && !tok_in.found) begin
				if (in_use && !cur_taken) begin
					nxt.run = run;
					if (run == len) begin
						nxt.found = 1'b1;
						nxt.start = SLOT_W'(int'(cell_idx) + 1 - int'(len));
					end
				end else begin
					nxt.run = '0;
				end
			end
			if (op == OP_FREE && cur_taken && owner_q[tok_in.row] == id) begin
				clr     = 1'b1;
				nxt.cnt = NSLOT_W'(tok_in.cnt + 1'b1);
			end
		end
		hit = commit.en && (int'(cell_idx) >= int'(commit.start)) &&
			(int'(cell_idx) - int'(commit.start) < int'(commit.len));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_in.valid ? nxt : '0;
			if (clr) begin
				taken_q[tok_in.row] <= 1'b0;
			end
			if (hit) begin
				taken_q[commit.row] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			owner_q[commit.row] <= id;
		end
	end

	assign tok_out = tok_q;

endmodule

// ----- hdl/first_fit_run_slot_allocator.sv -----
// First-fit slot allocator over a grid of up to 4 rows of 16 slots.
// Requests arrive on the s_ channel: take one slot, take a run of five
// adjacent slots inside one row, or free every slot of an owner id. Each
// request yields exactly one result transaction on the m_ channel with the
// status, the row and first slot of a placement, and the number freed.
// The grid is a chain of 16 cells, one per slot column; a scan token for
// each row walks the chain one cell per cycle, the rows following each
// other. An accepted request starts a scan: the token of each row is
// injected and passes the 16 cells, and when the last row's token leaves,
// the finish state loads the result into the output register. A new
// request is taken only after that load. Row count and slots per row
// must be written on the cfg port only while idle, by the user; the block
// does not enforce it. The grid shrinks or grows without losing occupied
// slots. Reset empties the grid and loads 3 rows of 15 slots. A result
// waits in the output register while the receiver stalls; a new request
// may be accepted meanwhile, its result held back until the register frees.
module first_fit_run_slot_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [1:0] operation, [17:2] owner_id, [23:18] zero
	input  logic [ffa_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [1:0] status, [3:2] row_index, [7:4] slot_index, [14:8] freed_count, [15] zero
	output logic [ffa_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [ffa_pkg::CFG_W-1:0]         cfg_wdata
);
	import ffa_pkg::*;

	state_t                  state_q, state_d;
	op_t                     op_q;
	logic [ID_W-1:0]         id_q;
	logic [ROW_COUNT_W-1:0]  row_count_q;
	logic [SLOTS_W-1:0]      slots_q;
	logic [NROW_W-1:0]       rows_use;
	logic [NSLOT_W-1:0]      slots_use;
	logic [NROW_W-1:0]       inj_q;
	logic                    have_q;
	logic [ROW_W-1:0]        row_q;
	logic [SLOT_W-1:0]       start_q;
	logic [FREED_W-1:0]      freed_q;
	logic                    m_tvalid_q;
	logic [OUT_TDATA_W-1:0]  m_tdata_q;
	logic                    accept;
	logic                    load;
	logic                    place;
	tok_t                    inj_tok;
	tok_t                    chain [MAX_SLOTS_PER_ROW+1];
	tok_t                    exit_tok;
	commit_t                 commit;
	status_t                 status;
	logic [OUT_ROW_W-1:0]    out_row;
	logic [OUT_SLOT_W-1:0]   out_slot;
	logic [FREED_W-1:0]      out_freed;

	always_comb begin
		rows_use  = (int'(row_count_q) > MAX_ROWS) ? NROW_W'(MAX_ROWS) : NROW_W'(row_count_q);
		slots_use = (int'(slots_q) > MAX_SLOTS_PER_ROW) ? NSLOT_W'(MAX_SLOTS_PER_ROW)
			: NSLOT_W'(slots_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_W'(3);
			slots_q     <= SLOTS_W'(15);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ROW_COUNT:     row_count_q <= cfg_wdata[ROW_COUNT_W-1:0];
				REG_SLOTS_PER_ROW: slots_q     <= cfg_wdata[SLOTS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		load     = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (exit_tok.valid && int'(exit_tok.row) == MAX_ROWS - 1) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(s_tdata[1:0]);
			id_q <= s_tdata[ID_W+1:2];
		end
	end

	always_comb begin
		inj_tok        = '0;
		inj_tok.valid  = (state_q == S_SCAN) && (int'(inj_q) < MAX_ROWS);
		inj_tok.row    = inj_q[ROW_W-1:0];
		inj_tok.active = NROW_W'(inj_q[ROW_W-1:0]) < rows_use;
	end

	assign chain[0] = inj_tok;

	for (genvar j = 0; j < MAX_SLOTS_PER_ROW; j++) begin : g_cell
		ffa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (SLOT_W'(j)),
			.op        (op_q),
			.id        (id_q),
			.slots_use (slots_use),
			.commit    (commit),
			.tok_in    (chain[j]),
			.tok_out   (chain[j+1])
		);
	end

	assign exit_tok = chain[MAX_SLOTS_PER_ROW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_q  <= '0;
			have_q <= 1'b0;
		end else if (accept) begin
			inj_q  <= '0;
			have_q <= 1'b0;
		end else begin
			if (inj_tok.valid) begin
				inj_q <= NROW_W'(inj_q + 1'b1);
			end
			if (exit_tok.valid && exit_tok.found && !have_q) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			freed_q <= '0;
		end else if (exit_tok.valid) begin
			freed_q <= FREED_W'(freed_q + FREED_W'(exit_tok.cnt));
			if (exit_tok.found && !have_q) begin
				row_q   <= exit_tok.row;
				start_q <= exit_tok.start;
			end
		end
	end

	always_comb begin
		place     = (op_q == OP_SINGLE) || (op_q == OP_RUN);
		status    = STAT_NO_ROOM;
		out_row   = '0;
		out_slot  = '0;
		out_freed = '0;
		if (op_q == OP_FREE) begin
			status    = (freed_q != '0) ? STAT_FREED : STAT_NOT_FOUND;
			out_freed = freed_q;
		end else if (place && have_q) begin
			status   = STAT_PLACED;
			out_row  = OUT_ROW_W'(row_q);
			out_slot = OUT_SLOT_W'(start_q);
		end
		commit.en    = load && place && have_q;
		commit.row   = row_q;
		commit.start = start_q;
		commit.len   = run_len(op_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= {1'b0, out_freed, out_slot, out_row, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_exit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		exit_tok.valid |-> state_q == S_SCAN)
		else $error("scan token left the chain outside a scan");

	a_commit_place: assert property (@(posedge clk) disable iff (!arst_n)
		commit.en |-> (op_q == OP_SINGLE || op_q == OP_RUN))
		else $error("slots committed for a request that places nothing");

	a_freed_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[14:8] != '0) |-> m_tdata[1:0] == STAT_FREED)
		else $error("nonzero freed count without freed status");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == S_FIN)
		else $error("result appeared without a finished request");

endmodule

// ----- tb/tb_first_fit_run_slot_allocator.sv -----
`timescale 1ns / 1ps

module tb_first_fit_run_slot_allocator;
	import ffa_pkg::*;

	localparam int GRID = MAX_ROWS * MAX_SLOTS_PER_ROW;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		status_t               status;
		logic [OUT_ROW_W-1:0]  row;
		logic [OUT_SLOT_W-1:0] slot;
		logic [FREED_W-1:0]    freed;
	} alloc_res_t;

	typedef struct {
		bit         fixed;
		alloc_res_t res;
	} req_note_t;

	typedef struct {
		bit                     is_cfg;
		op_t                    op;
		logic [ID_W-1:0]        id;
		bit                     fixed;
		alloc_res_t             res;
		logic [ROW_COUNT_W-1:0] rows;
		logic [SLOTS_W-1:0]     slots;
	} plan_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we;
	logic                   cfg_index;
	logic [CFG_W-1:0]       cfg_wdata;

	logic [ROW_COUNT_W-1:0] grid_rows;
	logic [SLOTS_W-1:0]     grid_slots;
	bit                     slot_busy [GRID];
	logic [ID_W-1:0]        slot_owner [GRID];

	alloc_res_t  alloc_expected_q [$];
	req_note_t   req_note_q [$];
	plan_row_t   plan [$];
	int          mismatches = 0;
	int          src_idle;
	int          sink_idle;
	int          quiet_cycles = 0;

	first_fit_run_slot_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic alloc_res_t alloc_predict(op_t op, logic [ID_W-1:0] id);
		alloc_res_t res;
		int nrows, nslots, len, r, s, k, freed;
		bit hit, clear;
		res = '{STAT_NO_ROOM, '0, '0, '0};
		nrows = (grid_rows > MAX_ROWS) ? MAX_ROWS : grid_rows;
		nslots = (grid_slots > MAX_SLOTS_PER_ROW) ? MAX_SLOTS_PER_ROW : grid_slots;
		if (op == OP_SINGLE || op == OP_RUN) begin
			len = (op == OP_RUN) ? RUN_LENGTH : 1;
			hit = 1'b0;
			for (r = 0; r < nrows && !hit; r++) begin
				for (s = 0; s + len <= nslots && !hit; s++) begin
					clear = 1'b1;
					for (k = 0; k < len; k++)
						if (slot_busy[r * MAX_SLOTS_PER_ROW + s + k])
							clear = 1'b0;
					if (clear) begin
						hit = 1'b1;
						for (k = 0; k < len; k++) begin
							slot_busy[r * MAX_SLOTS_PER_ROW + s + k] = 1'b1;
							slot_owner[r * MAX_SLOTS_PER_ROW + s + k] = id;
						end
						res.status = STAT_PLACED;
						res.row = OUT_ROW_W'(r);
						res.slot = OUT_SLOT_W'(s);
					end
				end
			end
		end else if (op == OP_FREE) begin
			freed = 0;
			for (k = 0; k < GRID; k++) begin
				if (slot_busy[k] && slot_owner[k] == id) begin
					slot_busy[k] = 1'b0;
					freed++;
				end
			end
			res.status = (freed == 0) ? STAT_NOT_FOUND : STAT_FREED;
			res.freed = FREED_W'(freed);
		end
		return res;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : result_monitor
		alloc_res_t want;
		alloc_res_t pred;
		req_note_t note;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (alloc_expected_q.size() == 0) begin
					$display("%0t: result expected none, actual %h", $time, m_tdata);
					mismatches++;
				end else begin
					want = alloc_expected_q.pop_front();
					check_field("status", want.status, m_tdata[1:0]);
					check_field("row_index", want.row, m_tdata[3:2]);
					check_field("slot_index", want.slot, m_tdata[7:4]);
					check_field("freed_count", want.freed, m_tdata[14:8]);
				end
			end
			if (s_tvalid && s_tready) begin
				pred = alloc_predict(op_t'(s_tdata[1:0]), s_tdata[17:2]);
				note = '{1'b0, pred};
				if (req_note_q.size() != 0)
					note = req_note_q.pop_front();
				alloc_expected_q.insert(alloc_expected_q.size(), note.fixed ? note.res : pred);
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic send_req(op_t op, logic [ID_W-1:0] id, bit fixed, alloc_res_t res);
		if ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle);
		end
		req_note_q.insert(req_note_q.size(), '{fixed, res});
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, id, op};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (alloc_expected_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_grid(logic [ROW_COUNT_W-1:0] rows, logic [SLOTS_W-1:0] slots);
		cfg_we <= 1'b1;
		cfg_index <= REG_ROW_COUNT;
		cfg_wdata <= CFG_W'(rows);
		@(posedge clk);
		cfg_index <= REG_SLOTS_PER_ROW;
		cfg_wdata <= CFG_W'(slots);
		@(posedge clk);
		cfg_we <= 1'b0;
		grid_rows = rows;
		grid_slots = slots;
	endtask

	function automatic void plan_req(op_t op, logic [ID_W-1:0] id);
		plan.insert(plan.size(), '{1'b0, op, id, 1'b0, '{STAT_NO_ROOM, '0, '0, '0}, '0, '0});
	endfunction

	function automatic void plan_chk(op_t op, logic [ID_W-1:0] id, status_t st, int row,
			int slot, int freed);
		plan.insert(plan.size(), '{1'b0, op, id, 1'b1,
			'{st, OUT_ROW_W'(row), OUT_SLOT_W'(slot), FREED_W'(freed)}, '0, '0});
	endfunction

	function automatic void plan_cfg(int rows, int slots);
		plan.insert(plan.size(), '{1'b1, OP_NONE, '0, 1'b0, '{STAT_NO_ROOM, '0, '0, '0},
			ROW_COUNT_W'(rows), SLOTS_W'(slots)});
	endfunction

	initial begin : stimulus
		logic [ID_W-1:0] owners [6];
		alloc_res_t none;
		op_t op;
		logic [ID_W-1:0] id;
		int blk, n, pick, k;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ROW_COUNT;
		cfg_wdata = '0;
		src_idle = 8;
		sink_idle = 81;
		grid_rows = 3'd3;
		grid_slots = 5'd15;
		none = '{STAT_NO_ROOM, '0, '0, '0};
		for (k = 0; k < GRID; k++) begin
			slot_busy[k] = 1'b0;
			slot_owner[k] = '0;
		end

		plan_chk(OP_FREE, 16'h1234, STAT_NOT_FOUND, 0, 0, 0);
		plan_chk(OP_SINGLE, 16'h0000, STAT_PLACED, 0, 0, 0);
		plan_chk(OP_SINGLE, 16'hFFFF, STAT_PLACED, 0, 1, 0);
		plan_chk(OP_RUN, 16'h00AA, STAT_PLACED, 0, 2, 0);
		plan_chk(OP_NONE, 16'h5555, STAT_NO_ROOM, 0, 0, 0);
		plan_chk(OP_FREE, 16'h0000, STAT_FREED, 0, 0, 1);
		plan_req(OP_SINGLE, 16'h8001);
		plan_req(OP_RUN, 16'h00AA);
		plan_req(OP_RUN, 16'h0BB0);
		plan_req(OP_FREE, 16'h00AA);
		plan_cfg(1, 4);
		plan_chk(OP_RUN, 16'h2222, STAT_NO_ROOM, 0, 0, 0);
		plan_req(OP_SINGLE, 16'h2222);
		plan_cfg(0, 16);
		plan_chk(OP_SINGLE, 16'h3333, STAT_NO_ROOM, 0, 0, 0);
		plan_chk(OP_RUN, 16'h3333, STAT_NO_ROOM, 0, 0, 0);
		plan_req(OP_FREE, 16'h0BB0);
		plan_cfg(7, 31);
		for (k = 0; k < 6; k++)
			plan_req(OP_RUN, 16'h4444);
		plan_req(OP_FREE, 16'h4444);
		plan_cfg(4, 0);
		plan_chk(OP_SINGLE, 16'h7FFF, STAT_NO_ROOM, 0, 0, 0);
		plan_cfg(2, 5);
		plan_req(OP_RUN, 16'h7FFF);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain_results();
				write_grid(plan[i].rows, plan[i].slots);
			end else begin
				send_req(plan[i].op, plan[i].id, plan[i].fixed, plan[i].res);
			end
		end

		foreach (owners[i])
			owners[i] = ID_W'($urandom_range(0, 65535));
		for (blk = 0; blk < 9; blk++) begin
			drain_results();
			src_idle = (blk < 3) ? 8 : (blk < 6) ? 81 : 0;
			sink_idle = (blk < 3) ? 81 : (blk < 6) ? 8 : 0;
			if (blk == 0 || blk == 8)
				write_grid(3'd4, 5'd16);
			else if (blk == 4)
				write_grid(3'd1, 5'd1);
			else if ($urandom_range(7) == 0)
				write_grid(ROW_COUNT_W'($urandom_range(0, 7)), SLOTS_W'($urandom_range(0, 31)));
			else
				write_grid(ROW_COUNT_W'($urandom_range(1, 4)), SLOTS_W'($urandom_range(5, 16)));
			owners[$urandom_range(5)] = ID_W'($urandom_range(0, 65535));
			owners[$urandom_range(5)] = ID_W'($urandom_range(0, 65535));
			for (n = 0; n < 100; n++) begin
				pick = $urandom_range(99);
				id = owners[$urandom_range(5)];
				if (pick < 4) begin
					op = OP_NONE;
					id = ID_W'($urandom_range(0, 65535));
				end else if (pick < 7) begin
					op = OP_FREE;
					id = ID_W'($urandom_range(0, 65535));
				end else if (pick < 47) begin
					op = OP_SINGLE;
				end else if (pick < 74) begin
					op = OP_RUN;
				end else begin
					op = OP_FREE;
				end
				send_req(op, id, 1'b0, none);
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
